>>> hdl/btlpm_pkg.sv
// btlpm_pkg: constants, payload types, controller state and command/status structs
// for the binary trie longest prefix match engine; no dependencies
`default_nettype none

package btlpm_pkg;

	localparam int NODES     = 4096;
	localparam int ROUTES    = 1024;
	localparam int ADDR_BITS = 32;

	localparam int WORD_W  = 32;
	localparam int NODE_W  = $clog2(NODES);
	localparam int USED_W  = $clog2(NODES + 1);
	localparam int ROUTE_W = 10;
	localparam int TAG_W   = ROUTE_W + 1;
	localparam int LEVEL_W = $clog2(ADDR_BITS + 1);
	localparam int POS_W   = $clog2(ADDR_BITS);

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [WORD_W-1:0]  address;
		logic [WORD_W-1:0]  mask;
		logic [ROUTE_W-1:0] route_index;
	} btlpm_req_t;

	typedef struct packed {
		logic               found;
		logic [ROUTE_W-1:0] match_route;
		logic               error;
	} btlpm_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FRESH,
		ST_PUSH
	} btlpm_state_t;

	typedef struct packed {
		logic is_lookup;
		logic route_ok;
		logic last;
		logic in_prefix;
		logic slot_zero;
		logic full;
	} btlpm_status_t;

	typedef struct packed {
		logic load;
		logic step;
		logic alloc;
		logic link;
		logic tag;
		logic fresh_wr;
		logic fresh_tag;
		logic finish;
		logic fin_err;
		logic push;
	} btlpm_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/btlpm_if.sv
// btlpm_req_if / btlpm_rsp_if: valid/ready channels for requests and results
// depends on btlpm_pkg
`default_nettype none

interface btlpm_req_if;
	import btlpm_pkg::*;
	logic       valid;
	logic       ready;
	btlpm_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface btlpm_rsp_if;
	import btlpm_pkg::*;
	logic       valid;
	logic       ready;
	btlpm_rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/btlpm_ram.sv
// btlpm_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module btlpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/btlpm_ctrl.sv
// btlpm_ctrl: controller state machine sequencing insert and lookup walks
// depends on btlpm_pkg
`default_nettype none

module btlpm_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    req_valid,
	output logic                         req_ready,
	output logic                         rsp_valid,
	input  wire logic                    rsp_ready,
	input  wire btlpm_pkg::btlpm_status_t st,
	output btlpm_pkg::btlpm_ctrl_t       ctrl
);
	import btlpm_pkg::*;

	btlpm_state_t state_q, state_d;
	logic         rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctrl.load = 1'b1;
					state_d   = ST_WALK;
				end
			end
			ST_WALK: begin
				if (st.is_lookup) begin
					if (st.last || st.slot_zero) begin
						ctrl.finish = 1'b1;
						state_d     = ST_PUSH;
					end else begin
						ctrl.step = 1'b1;
					end
				end else if (!st.route_ok) begin
					ctrl.finish = 1'b1;
					state_d     = ST_PUSH;
				end else if (st.last || !st.in_prefix) begin
					// end of prefix on an existing node
					ctrl.tag    = 1'b1;
					ctrl.finish = 1'b1;
					state_d     = ST_PUSH;
				end else if (!st.slot_zero) begin
					ctrl.step = 1'b1;
				end else if (st.full) begin
					ctrl.finish  = 1'b1;
					ctrl.fin_err = 1'b1;
					state_d      = ST_PUSH;
				end else begin
					// first missing child: hook a fresh node under the current one
					ctrl.link  = 1'b1;
					ctrl.alloc = 1'b1;
					state_d    = ST_FRESH;
				end
			end
			ST_FRESH: begin
				ctrl.fresh_wr = 1'b1;
				if (st.last || !st.in_prefix) begin
					ctrl.fresh_tag = 1'b1;
					ctrl.finish    = 1'b1;
					state_d        = ST_PUSH;
				end else if (st.full) begin
					ctrl.finish  = 1'b1;
					ctrl.fin_err = 1'b1;
					state_d      = ST_PUSH;
				end else begin
					ctrl.alloc = 1'b1;
				end
			end
			ST_PUSH: begin
				if (!rsp_valid_q || rsp_ready) begin
					ctrl.push = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/btlpm_dp.sv
// btlpm_dp: trie node stores, walk registers, allocation counter and result registers
// depends on btlpm_pkg and btlpm_ram
`default_nettype none

module btlpm_dp (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire btlpm_pkg::btlpm_req_t  req_data,
	input  wire btlpm_pkg::btlpm_ctrl_t ctrl,
	output btlpm_pkg::btlpm_status_t    st,
	output btlpm_pkg::btlpm_rsp_t       rsp_data
);
	import btlpm_pkg::*;

	// item and walk registers
	cmd_t               cmd_q;
	logic [WORD_W-1:0]  addr_q;
	logic [WORD_W-1:0]  mask_q;
	logic [ROUTE_W-1:0] route_q;
	logic [LEVEL_W-1:0] level_q;
	logic [NODE_W-1:0]  cur_q;
	logic [TAG_W-1:0]   best_q;
	btlpm_rsp_t         pend_q;
	btlpm_rsp_t         rsp_q;

	// root children live in flops so reset clears them
	logic [NODE_W-1:0]  root_left_q;
	logic [NODE_W-1:0]  root_right_q;
	logic [USED_W-1:0]  used_q;

	logic [NODE_W-1:0]  left_rd, right_rd;
	logic [TAG_W-1:0]   route_rd;
	logic [POS_W-1:0]   pos_c;
	logic               addr_bit, cur_root;
	logic [NODE_W-1:0]  child_left, child_right, slot_c, fresh_idx;
	logic [TAG_W-1:0]   best_now;
	logic               left_we, right_we, route_we;
	logic [NODE_W-1:0]  left_wd, right_wd;
	logic [TAG_W-1:0]   route_wd;

	assign pos_c       = POS_W'(ADDR_BITS - 1) - level_q[POS_W-1:0];
	assign addr_bit    = addr_q[pos_c];
	assign cur_root    = (cur_q == '0);
	assign child_left  = cur_root ? root_left_q : left_rd;
	assign child_right = cur_root ? root_right_q : right_rd;
	assign slot_c      = addr_bit ? child_right : child_left;
	assign fresh_idx   = used_q[NODE_W-1:0];
	assign best_now    = (!cur_root && route_rd[ROUTE_W]) ? route_rd : best_q;

	always_comb begin
		st.is_lookup = (cmd_q == CMD_LOOKUP);
		st.route_ok  = ({1'b0, route_q} < TAG_W'(ROUTES));
		st.last      = (level_q == LEVEL_W'(ADDR_BITS));
		st.in_prefix = mask_q[pos_c];
		st.slot_zero = (slot_c == '0);
		st.full      = (used_q >= USED_W'(NODES));
	end

	// store writes, all at the current node
	assign left_we  = (ctrl.link && !cur_root && !addr_bit) || ctrl.fresh_wr;
	assign right_we = (ctrl.link && !cur_root && addr_bit) || ctrl.fresh_wr;
	assign left_wd  = (ctrl.alloc && !addr_bit) ? fresh_idx : '0;
	assign right_wd = (ctrl.alloc && addr_bit) ? fresh_idx : '0;
	assign route_we = (ctrl.tag && !cur_root) || ctrl.fresh_wr;
	assign route_wd = (ctrl.tag || ctrl.fresh_tag) ? {1'b1, route_q} : '0;

	btlpm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_left (
		.clk   (clk),
		.we    (left_we),
		.waddr (cur_q),
		.wdata (left_wd),
		.raddr (slot_c),
		.rdata (left_rd)
	);

	btlpm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_right (
		.clk   (clk),
		.we    (right_we),
		.waddr (cur_q),
		.wdata (right_wd),
		.raddr (slot_c),
		.rdata (right_rd)
	);

	btlpm_ram #(.WIDTH(TAG_W), .DEPTH(NODES)) u_route (
		.clk   (clk),
		.we    (route_we),
		.waddr (cur_q),
		.wdata (route_wd),
		.raddr (slot_c),
		.rdata (route_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_left_q  <= '0;
			root_right_q <= '0;
			used_q       <= USED_W'(1);
		end else begin
			if (ctrl.link && cur_root) begin
				if (addr_bit) begin
					root_right_q <= fresh_idx;
				end else begin
					root_left_q <= fresh_idx;
				end
			end
			if (ctrl.alloc) begin
				used_q <= used_q + USED_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q   <= req_data.cmd;
			addr_q  <= req_data.address;
			mask_q  <= req_data.mask;
			route_q <= req_data.route_index;
			level_q <= '0;
			cur_q   <= '0;
			best_q  <= '0;
		end else if (ctrl.step) begin
			cur_q   <= slot_c;
			level_q <= level_q + LEVEL_W'(1);
			best_q  <= best_now;
		end else if (ctrl.alloc) begin
			cur_q   <= fresh_idx;
			level_q <= level_q + LEVEL_W'(1);
		end
		if (ctrl.finish) begin
			pend_q.found       <= st.is_lookup && best_now[ROUTE_W];
			pend_q.match_route <= (st.is_lookup && best_now[ROUTE_W]) ?
				best_now[ROUTE_W-1:0] : '0;
			pend_q.error       <= ctrl.fin_err;
		end
		if (ctrl.push) begin
			rsp_q <= pend_q;
		end
	end

	assign rsp_data = rsp_q;

endmodule

`default_nettype wire

>>> hdl/binary_trie_longest_prefix_match.sv
// binary_trie_longest_prefix_match: top level of the trie based longest prefix match engine
// depends on btlpm_pkg, btlpm_if, btlpm_ctrl, btlpm_dp (and btlpm_ram below it)
//
// One request in, one result out. An insert (cmd 0) walks the leading ones of
// mask from the top address bit, following address bits down a one-bit-per-level
// trie, allocating missing nodes, and tags the final node with route_index; a
// mask whose top bit is clear installs nothing. When the node store runs out the
// result carries error and the nodes already taken stay in the trie. A lookup
// (cmd 1) walks the address bits and returns the route of the deepest tagged node
// on its path, with found set, or found clear and match_route zero. The walk goes
// down one trie level per step of the single read of the node stores (registered
// read data feeds the next read address); the block accepts a request in its idle
// state and hands the result to the output register before taking the next one.
// A finished result sits in an output register, so the next request is taken
// while the previous result still waits. No clearing pass is needed after reset:
// the root's children are flops and every other node is written when it is
// allocated.
`default_nettype none

module binary_trie_longest_prefix_match (
	input  wire logic  clk,
	input  wire logic  arst_n,
	btlpm_req_if.sink   req,
	btlpm_rsp_if.source rsp
);
	import btlpm_pkg::*;

	// command and status between the sequencer and the datapath
	btlpm_ctrl_t   ctrl;
	btlpm_status_t st;

	// controller: walk sequencing, request and result handshakes
	btlpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.st        (st),
		.ctrl      (ctrl)
	);

	// datapath: node stores, walk state, node allocator, result registers
	btlpm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.ctrl     (ctrl),
		.st       (st),
		.rsp_data (rsp.data)
	);

endmodule

`default_nettype wire

>>> verif/btlpm_route_checker.sv
// btlpm_route_checker: watches the request and result channels, predicts each result
// from its own copy of the trie and compares; depends on btlpm_pkg and btlpm_if
`default_nettype none

module btlpm_route_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	btlpm_req_if      req,
	btlpm_rsp_if      rsp,
	output int        failures,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import btlpm_pkg::*;

	localparam int TAGGED = TAG_W - 1;

	logic [NODE_W-1:0] zero_child [NODES];
	logic [NODE_W-1:0] one_child [NODES];
	logic [TAG_W-1:0]  node_tag [NODES];
	int unsigned       nodes_taken;
	btlpm_rsp_t        route_queue [$];
	int                mismatches;

	// walks the trie for one request, updating it on insert
	function automatic btlpm_rsp_t walk_trie(input btlpm_req_t item);
		logic [NODE_W-1:0] node;
		logic [NODE_W-1:0] next_node;
		logic [TAG_W-1:0]  best;
		bit                walked;
		bit                exhausted;
		int                pos;
		btlpm_rsp_t        answer;
		answer = '0;
		node = '0;
		best = '0;
		walked = 1'b0;
		exhausted = 1'b0;
		if (item.cmd == CMD_INSERT) begin
			if (int'(item.route_index) >= ROUTES)
				return answer;
			for (int lvl = 0; lvl < ADDR_BITS; lvl++) begin
				pos = ADDR_BITS - 1 - lvl;
				if (!item.mask[pos])
					break;
				next_node = item.address[pos] ? one_child[node] : zero_child[node];
				if (next_node == '0) begin
					if (nodes_taken >= NODES) begin
						exhausted = 1'b1;
						break;
					end
					next_node = nodes_taken[NODE_W-1:0];
					nodes_taken++;
					zero_child[next_node] = '0;
					one_child[next_node] = '0;
					node_tag[next_node] = '0;
					if (item.address[pos])
						one_child[node] = next_node;
					else
						zero_child[node] = next_node;
				end
				node = next_node;
				walked = 1'b1;
			end
			answer.error = exhausted;
			if (walked && !exhausted)
				node_tag[node] = {1'b1, item.route_index};
		end else begin
			for (int lvl = 0; lvl < ADDR_BITS; lvl++) begin
				pos = ADDR_BITS - 1 - lvl;
				next_node = item.address[pos] ? one_child[node] : zero_child[node];
				if (next_node == '0)
					break;
				node = next_node;
				if (node_tag[node][TAGGED])
					best = node_tag[node];
			end
			answer.found = best[TAGGED];
			answer.match_route = best[TAGGED] ? best[ROUTE_W-1:0] : '0;
		end
		return answer;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		btlpm_rsp_t want;
		btlpm_rsp_t got;
		if (!arst_n) begin
			zero_child[0] = '0;
			one_child[0] = '0;
			node_tag[0] = '0;
			nodes_taken = 1;
			route_queue.delete();
			mismatches = 0;
			failures <= 0;
			pending <= 0;
		end else begin
			// results first: a result never belongs to a request taken on the same edge
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				if (route_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with none pending: found=%0b route=%0d error=%0b",
							$time, got.found, got.match_route, got.error);
				end else begin
					want = route_queue.pop_front();
					if (got.found !== want.found || got.match_route !== want.match_route ||
							got.error !== want.error) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: result mismatch: expected found=%0b route=%0d error=%0b",
								$time, want.found, want.match_route, want.error);
							$display("%0t: result mismatch: got found=%0b route=%0d error=%0b",
								$time, got.found, got.match_route, got.error);
						end
					end
				end
			end
			if (req.valid && req.ready)
				route_queue.push_back(walk_trie(req.data));
			failures <= mismatches;
			pending <= route_queue.size();
		end
	end

endmodule

`default_nettype wire

>>> verif/binary_trie_longest_prefix_match_test.sv
// binary_trie_longest_prefix_match_test: drives inserts and lookups into the trie engine
// and gives the verdict; depends on btlpm_pkg, btlpm_if and btlpm_route_checker
`default_nettype none

module binary_trie_longest_prefix_match_test;
	timeunit 1ns;
	timeprecision 1ps;

	import btlpm_pkg::*;

	// receiver behavior, picked afresh at random whenever the current mode runs out
	typedef enum int {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_SPARSE,
		RDY_PERIODIC
	} ready_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   failures;
	int   pending;

	btlpm_req_if req_ch ();
	btlpm_rsp_if rsp_ch ();

	binary_trie_longest_prefix_match dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// the checker sees every transfer on both channels and keeps the score
	btlpm_route_checker route_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.failures (failures),
		.pending  (pending)
	);

	always #2 clk = ~clk;

	// generous ceiling: the slowest legal run is well under a fifth of this
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// result side backpressure: long stretches of always ready, coin flips, sparse
	// acceptance and a fixed one-in-five stall, each held for a random while
	ready_mode_t ready_mode = RDY_ALWAYS;
	int          mode_left = 0;
	int          ready_phase = 0;

	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(32, 256);
		end
		mode_left--;
		ready_phase++;
		case (ready_mode)
			RDY_ALWAYS:   rsp_ch.ready <= 1'b1;
			RDY_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
			RDY_SPARSE:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
			default:      rsp_ch.ready <= (ready_phase % 5 != 0);
		endcase
	end

	// a handful of home prefixes that most random routes and lookups grow from,
	// so lookups land on tagged paths instead of falling off near the root
	logic [31:0] home_prefix [12];
	// addresses of recent long inserts, for lookups that should hit them
	logic [31:0] recent_addr [16];
	int          recent_wr;
	int          burst_left;

	// mask with len leading ones, a zero after them and junk below;
	// the junk must not change what gets installed
	function automatic logic [31:0] prefix_mask(input int len, input logic [31:0] junk);
		if (len <= 0)
			return junk & 32'h7FFF_FFFF;
		if (len >= 32)
			return 32'hFFFF_FFFF;
		return ~(32'hFFFF_FFFF >> len) | (junk & (32'hFFFF_FFFF >> (len + 1)));
	endfunction

	// prefix length mix: a few empty masks, some host routes, the rest spread out
	function automatic int draw_length();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 0;
		if (r <= 2)
			return 32;
		return $urandom_range(1, 31);
	endfunction

	// one request transfer; the sender runs in bursts with random gaps after them,
	// and valid stays up between transfers of a burst
	task automatic put_request(input cmd_t cmd, input logic [31:0] address,
			input logic [31:0] mask, input logic [ROUTE_W-1:0] route);
		btlpm_req_t item;
		int         gap;
		item.cmd = cmd;
		item.address = address;
		item.mask = mask;
		item.route_index = route;
		req_ch.valid <= 1'b1;
		req_ch.data <= item;
		do
			@(posedge clk);
		while (!req_ch.ready);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// random traffic; without flood the routes stay close to the home prefixes and
	// the store keeps room, with flood most inserts are host routes at random
	// addresses, which soon exhausts the store and keeps hitting the full case
	task automatic random_items(input int count, input bit flood);
		int          pick;
		logic [31:0] addr;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			addr = home_prefix[$urandom_range(0, 11)]
				^ ($urandom & (32'hFFFF_FFFF >> $urandom_range(12, 32)));
			if (flood && pick < 40) begin
				addr = $urandom;
				recent_addr[recent_wr] = addr;
				recent_wr = (recent_wr + 1) % 16;
				put_request(CMD_INSERT, addr,
					prefix_mask(($urandom_range(0, 3) == 0) ? $urandom_range(16, 31) : 32,
						$urandom),
					ROUTE_W'($urandom_range(0, ROUTES - 1)));
			end else if (flood && pick < 60) begin
				// near or exactly on a recent host route
				put_request(CMD_LOOKUP,
					recent_addr[$urandom_range(0, 15)] ^ (32'hFFFF_FFFF >> $urandom_range(24, 32)),
					$urandom, ROUTE_W'($urandom_range(0, 1023)));
			end else if (pick < 45) begin
				put_request(CMD_INSERT, addr, prefix_mask(draw_length(), $urandom),
					ROUTE_W'($urandom_range(0, ROUTES - 1)));
			end else if (pick < 90) begin
				put_request(CMD_LOOKUP, addr, $urandom, ROUTE_W'($urandom_range(0, 1023)));
			end else begin
				// noise: any command, any address, any mask
				put_request(pick[0] ? CMD_LOOKUP : CMD_INSERT, $urandom, $urandom,
					ROUTE_W'($urandom_range(0, 1023)));
			end
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < 12; i++)
			home_prefix[i] = $urandom;
		for (int i = 0; i < 16; i++)
			recent_addr[i] = home_prefix[i % 12];
		recent_wr = 0;
		burst_left = $urandom_range(1, 24);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		// empty trie: nothing matches
		put_request(CMD_LOOKUP, 32'h0000_0000, 32'h0, 10'd0);
		// top mask bit clear installs nothing, even with ones below it
		put_request(CMD_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 10'd3);
		put_request(CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 10'd5);
		put_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
		put_request(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 10'h3FF);
		// nested routes /8, /16 and a full-length /32 with the top route number
		put_request(CMD_INSERT, 32'h0A00_0000, 32'hFF00_0000, 10'd1);
		put_request(CMD_INSERT, 32'h0A0B_0000, 32'hFFFF_0000, 10'd2);
		put_request(CMD_INSERT, 32'h0A0B_0C0D, 32'hFFFF_FFFF, 10'd1023);
		put_request(CMD_LOOKUP, 32'h0A0B_0C0D, 32'h0, 10'd0);
		put_request(CMD_LOOKUP, 32'h0A0B_0C0E, 32'h0, 10'd0);
		put_request(CMD_LOOKUP, 32'h0A0C_0000, 32'h0, 10'd0);
		// /1 on the zero side: untagged left steps below it keep that route
		put_request(CMD_INSERT, 32'h0000_0000, 32'h8000_0000, 10'd7);
		put_request(CMD_LOOKUP, 32'h0100_0000, 32'h0, 10'd0);
		put_request(CMD_LOOKUP, 32'h0A0B_0C0D, 32'h0, 10'd0);
		// overwrite the /8 with junk after the first zero in the mask
		put_request(CMD_INSERT, 32'h0A00_0000, 32'hFF00_FF00, 10'd100);
		put_request(CMD_LOOKUP, 32'h0A99_0000, 32'h0, 10'd0);
		// route zero on the all-ones host: found with best route zero
		put_request(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd0);
		put_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 10'd0);
		// prefix bits below the mask are ignored
		put_request(CMD_INSERT, 32'hC0FF_EE12, 32'hC000_0000, 10'd511);
		put_request(CMD_LOOKUP, 32'hC000_0000, 32'h0, 10'd0);
		// an existing but untagged node does not count as a match
		put_request(CMD_LOOKUP, 32'h8000_0000, 32'h0, 10'd0);
		put_request(CMD_INSERT, 32'h8000_0000, 32'h8000_0000, 10'd512);
		put_request(CMD_LOOKUP, 32'h8000_0000, 32'h0, 10'd0);

		// random part: growth around the home prefixes, then a flood that fills the store
		random_items(800, 1'b0);
		random_items(550, 1'b1);

		req_ch.valid <= 1'b0;
		// let the checker count the last transfer before polling
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// room for a late or extra result to show up
		repeat (40) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

>>> binary_trie_longest_prefix_match.f
hdl/btlpm_pkg.sv
hdl/btlpm_if.sv
hdl/btlpm_ram.sv
hdl/btlpm_ctrl.sv
hdl/btlpm_dp.sv
hdl/binary_trie_longest_prefix_match.sv
verif/btlpm_route_checker.sv
verif/binary_trie_longest_prefix_match_test.sv
